/* design/tpra_pkg.sv */
// ----------------------------------------------------------------------------
// tpra_pkg: shared definitions for the tachometer period-to-rpm averager
// Field widths, averaging constants, event codes and register indexes.
// ----------------------------------------------------------------------------
package tpra_pkg;

  // Field and state widths.
  localparam int unsigned CapW   = 16;
  localparam int unsigned OvfW   = 8;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned NumW   = 22;
  localparam int unsigned ReqW   = 12;
  localparam int unsigned TickW  = 24;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned CfgW   = 22;

  // Number of samples summed per published average.
  localparam int unsigned SamplesAveraged = 11;
  // Overflow ticks tolerated before the fan counts as stopped.
  localparam int unsigned StallOverflows  = 1;

  // Divider geometry: the dividend is either the numerator or the speed sum.
  localparam int unsigned DivW    = NumW;
  localparam int unsigned DivCntW = $clog2(DivW);

  // Event codes carried by the opcode field.
  typedef enum logic [1:0] {
    OP_RISE = 2'd0,
    OP_FALL = 2'd1,
    OP_TICK = 2'd2
  } opcode_t;

  // Configuration register indexes.
  localparam logic REG_RPM_NUMERATOR   = 1'b0;
  localparam logic REG_REQUESTED_SPEED = 1'b1;

endpackage

/* design/tpra_serial_div.sv */
// ----------------------------------------------------------------------------
// tpra_serial_div: bit-serial restoring divider
// Produces one quotient bit per cycle by shifting the dividend through a
// partial remainder register.
// ----------------------------------------------------------------------------
module tpra_serial_div
  import tpra_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DivW-1:0]  dividend,
  input  logic [TickW-1:0] divisor,
  output logic             done,
  output logic [DivW-1:0]  quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [DivW-1:0]    quo_r, quo_nxt;
  logic [TickW-1:0]   rem_r, rem_nxt;
  logic [TickW-1:0]   dsr_r, dsr_nxt;
  logic [TickW:0]     shifted;
  logic [TickW+1:0]   diff;

  // One restoring step: bring in the next dividend bit and try to subtract.
  assign shifted = {rem_r, quo_r[DivW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DivCntW'(DivW - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DivW-2:0], ~diff[TickW+1]};
      rem_nxt = diff[TickW+1] ? shifted[TickW-1:0] : diff[TickW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath shift registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/tach_period_rpm_averager_top.sv */
// ----------------------------------------------------------------------------
// tach_period_rpm_averager_top: fan tachometer period-to-rpm averager
// Turns rising/falling capture and timer overflow beats into averaged speed.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel (in_valid/in_stall) carries one event per beat: a rising
// edge capture, a falling edge capture or a timer overflow tick. Every event
// yields exactly one beat on the output channel (out_valid/out_stall) with the
// held speed, held speed error and three event flags.
// Events are handled one at a time. A rising edge, an overflow tick or a
// falling edge with a zero period that is not the averaging edge passes
// through EVAL and EMIT into the output register. A falling edge that needs
// a division also passes through DIVIDE: the 22-bit bit-serial divider
// produces one quotient bit per cycle, and it is used both for numerator/ticks
// and for sum/sample count on the averaging edge. in_stall is high while an
// event is in progress, so no new event is taken before its result is stored.
// A finished result sits in the output register; while out_stall is high the
// result holds, a new result waits in the last step and no event is taken.
// Synchronous reset clears all speed state, restores the register defaults
// and empties the output register. Configuration writes take effect at the
// next clock edge and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module tach_period_rpm_averager_top
  import tpra_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write port
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CfgW-1:0]          cfg_wdata,
  // Event channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  logic [CapW-1:0]          in_capture_time,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SpeedW-1:0]        out_current_speed,
  output logic signed [ErrW-1:0]   out_speed_error,
  output logic                     out_average_ready,
  output logic                     out_stalled,
  output logic                     out_period_fault
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [NumW-1:0]   num_r, num_nxt;
  logic [ReqW-1:0]   req_r, req_nxt;

  // Latched event.
  logic [1:0]        op_r, op_nxt;
  logic [CapW-1:0]   cap_r, cap_nxt;

  // Measurement state.
  logic [CapW-1:0]   rise_r, rise_nxt;
  logic [OvfW-1:0]   ovf_r, ovf_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [NumW-1:0]   sum_r, sum_nxt;
  logic [SpeedW-1:0] speed_r, speed_nxt;
  logic signed [ErrW-1:0] err_r, err_nxt;
  logic              publish_r, publish_nxt;

  // Event flags of the result in progress.
  logic              ready_flag_r, ready_flag_nxt;
  logic              stall_flag_r, stall_flag_nxt;
  logic              fault_flag_r, fault_flag_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [SpeedW-1:0] out_speed_r, out_speed_nxt;
  logic signed [ErrW-1:0] out_err_r, out_err_nxt;
  logic              out_ready_r, out_ready_nxt;
  logic              out_stalled_r, out_stalled_nxt;
  logic              out_fault_r, out_fault_nxt;

  // Divider interface.
  logic              div_start;
  logic [DivW-1:0]   div_dividend;
  logic [TickW-1:0]  div_divisor;
  logic              div_done;
  logic [DivW-1:0]   div_quotient;

  // Combinational helpers.
  logic [TickW-1:0]  ticks;
  logic [OvfW-1:0]   ovf_inc;
  logic [IdxW-1:0]   idx_inc;
  logic [NumW:0]     sum_add;
  logic [SpeedW-1:0] avg_sat;

  // Period in timer ticks, taken modulo 2^24.
  assign ticks   = {ovf_r, {CapW{1'b0}}} + TickW'(cap_r) - TickW'(rise_r);
  assign ovf_inc = (ovf_r == {OvfW{1'b1}}) ? ovf_r : ovf_r + 1'b1;
  assign idx_inc = idx_r + 1'b1;
  assign sum_add = {1'b0, sum_r} + {1'b0, div_quotient};
  assign avg_sat = (|div_quotient[DivW-1:SpeedW]) ? {SpeedW{1'b1}}
                                                   : div_quotient[SpeedW-1:0];

  tpra_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer and state updates.
  always_comb begin
    state_nxt       = state_r;
    num_nxt         = num_r;
    req_nxt         = req_r;
    op_nxt          = op_r;
    cap_nxt         = cap_r;
    rise_nxt        = rise_r;
    ovf_nxt         = ovf_r;
    idx_nxt         = idx_r;
    sum_nxt         = sum_r;
    speed_nxt       = speed_r;
    err_nxt         = err_r;
    publish_nxt     = publish_r;
    ready_flag_nxt  = ready_flag_r;
    stall_flag_nxt  = stall_flag_r;
    fault_flag_nxt  = fault_flag_r;
    out_valid_nxt   = out_valid_r;
    out_speed_nxt   = out_speed_r;
    out_err_nxt     = out_err_r;
    out_ready_nxt   = out_ready_r;
    out_stalled_nxt = out_stalled_r;
    out_fault_nxt   = out_fault_r;
    div_start       = 1'b0;
    div_dividend    = num_r;
    div_divisor     = ticks;

    // Configuration writes.
    if (cfg_we) begin
      if (cfg_index == REG_RPM_NUMERATOR) begin
        num_nxt = cfg_wdata[NumW-1:0];
      end else begin
        req_nxt = cfg_wdata[ReqW-1:0];
      end
    end

    // The output register empties when its beat is taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          cap_nxt   = in_capture_time;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        ready_flag_nxt = 1'b0;
        stall_flag_nxt = 1'b0;
        fault_flag_nxt = 1'b0;
        publish_nxt    = 1'b0;
        state_nxt      = ST_EMIT;
        unique case (op_r)
          OP_RISE: begin
            ovf_nxt  = '0;
            rise_nxt = cap_r;
          end
          OP_FALL: begin
            rise_nxt       = '0;
            fault_flag_nxt = (ticks == '0);
            if (idx_inc > IdxW'(SamplesAveraged)) begin
              // Averaging edge: this sample is dropped, the sum is divided.
              publish_nxt  = 1'b1;
              div_start    = 1'b1;
              div_dividend = sum_r;
              div_divisor  = TickW'(SamplesAveraged);
              state_nxt    = ST_DIVIDE;
            end else begin
              idx_nxt = idx_inc;
              if (ticks != '0) begin
                div_start = 1'b1;
                state_nxt = ST_DIVIDE;
              end
            end
          end
          OP_TICK: begin
            ovf_nxt = ovf_inc;
            if (ovf_inc > OvfW'(StallOverflows)) begin
              speed_nxt      = '0;
              stall_flag_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
          if (publish_r) begin
            speed_nxt      = avg_sat;
            err_nxt        = $signed({5'b0, req_r}) - $signed({1'b0, avg_sat});
            idx_nxt        = '0;
            sum_nxt        = '0;
            ready_flag_nxt = 1'b1;
          end else begin
            sum_nxt = sum_add[NumW] ? {NumW{1'b1}} : sum_add[NumW-1:0];
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_speed_nxt   = speed_r;
          out_err_nxt     = err_r;
          out_ready_nxt   = ready_flag_r;
          out_stalled_nxt = stall_flag_r;
          out_fault_nxt   = fault_flag_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Registers: control and architectural state are reset, payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_r       <= NumW'(1875000);
      req_r       <= ReqW'(1000);
      rise_r      <= '0;
      ovf_r       <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      speed_r     <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_r       <= num_nxt;
      req_r       <= req_nxt;
      rise_r      <= rise_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      speed_r     <= speed_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    cap_r         <= cap_nxt;
    publish_r     <= publish_nxt;
    ready_flag_r  <= ready_flag_nxt;
    stall_flag_r  <= stall_flag_nxt;
    fault_flag_r  <= fault_flag_nxt;
    out_speed_r   <= out_speed_nxt;
    out_err_r     <= out_err_nxt;
    out_ready_r   <= out_ready_nxt;
    out_stalled_r <= out_stalled_nxt;
    out_fault_r   <= out_fault_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_current_speed = out_speed_r;
  assign out_speed_error   = out_err_r;
  assign out_average_ready = out_ready_r;
  assign out_stalled       = out_stalled_r;
  assign out_period_fault  = out_fault_r;

endmodule
